/* hdl/sbcfp_pkg.sv */
// ----------------------------------------------------------------------------
// sbcfp_pkg
// Shared types and constants for the SBC frame packetizer.
// ----------------------------------------------------------------------------
package sbcfp_pkg;

    localparam int HEADER_BYTES     = 4;
    localparam int MAX_CAPACITY_DEF = 1024;
    localparam int JOB_DEPTH_DEF    = 4;
    localparam int CAPACITY_MIN     = 8;
    localparam int CAPACITY_RESET   = 330;
    localparam int SIZE_W           = 11;

    localparam logic [7:0] SYNC_BYTE = 8'h9C;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_PACKET = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_BAD_SYNC      = 3'd1,
        ERR_TOO_LARGE     = 3'd2,
        ERR_SHORT_HEADER  = 3'd3,
        ERR_SHORT_PAYLOAD = 3'd4
    } t_err;

    // One unit of work for the back end. A header job expands to an optional
    // packet-ready result followed by the header bytes; any other job is a
    // single result.
    typedef struct packed {
        logic                               hdr;
        t_kind                              kind;
        logic [7:0]                         data;
        logic [9:0]                         offset;
        logic [10:0]                        length;
        t_err                               code;
        logic                               flush;
        logic [HEADER_BYTES-1:0][7:0]       hbytes;
    } t_job;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [9:0]  offset;
        logic [10:0] length;
        t_err        code;
        logic        last;
    } t_result;

endpackage

/* hdl/sbcfp_front.sv */
// ----------------------------------------------------------------------------
// sbcfp_front
// Input parser: collects headers, sizes frames, tracks packet fill and
// turns input bytes and end commands into jobs for the back end.
// ----------------------------------------------------------------------------
module sbcfp_front #(
    parameter int MAX_CAPACITY = sbcfp_pkg::MAX_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_command,
    input  logic [7:0]        i_in_byte,
    input  logic              i_q_full,
    input  logic              i_cfg_valid,
    input  logic [10:0]       i_cfg_data,
    output logic              o_job_push,
    output sbcfp_pkg::t_job   o_job
);
    import sbcfp_pkg::*;

    localparam int FW      = $clog2(MAX_CAPACITY + 1);
    localparam int CW      = ((FW > SIZE_W) ? FW : SIZE_W) + 2;
    localparam int CAP_RST = (CAPACITY_RESET > MAX_CAPACITY) ? MAX_CAPACITY : CAPACITY_RESET;

    function automatic logic [10:0] f_payload_size(input logic [7:0] b1,
                                                   input logic [7:0] pool);
        logic [3:0]  sb;
        logic [2:0]  blk;
        logic [10:0] prod;
        logic [12:0] base;
        logic [12:0] bits;
        logic [13:0] sum;
        sb   = b1[0] ? 4'd8 : 4'd4;
        blk  = 3'(b1[5:4]) + 3'd1;
        prod = 11'(blk) * 11'(pool);
        base = {prod, 2'b00};
        case (b1[3:2])
            2'd0: begin
                sb   = sb >> 1;
                bits = base;
            end
            2'd1: bits = base << 1;
            2'd2: bits = base;
            2'd3: bits = base + 13'(sb);
            default: bits = base;
        endcase
        sum = 14'(bits) + 14'd7;
        return 11'(sb) + 11'(sum >> 3);
    endfunction

    logic [1:0]         r_hcnt, n_hcnt;
    logic               r_in_pay, n_in_pay;
    logic               r_halted, n_halted;
    logic [SIZE_W-1:0]  r_left, n_left;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_cap;
    logic [7:0]         r_hold0, r_hold1, r_hold2;
    logic [SIZE_W-1:0]  r_size;
    logic               accept;
    logic               job_vld;
    t_job               job;
    logic [FW-1:0]      base;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_hcnt   = r_hcnt;
        n_in_pay = r_in_pay;
        n_halted = r_halted;
        n_left   = r_left;
        n_fill   = r_fill;
        job_vld  = 1'b0;
        job      = '0;
        base     = r_fill;
        job.kind = KIND_BYTE;
        job.code = ERR_NONE;
        if (accept && !r_halted) begin
            if (i_command) begin
                if (r_in_pay) begin
                    job_vld  = 1'b1;
                    job.kind = KIND_ERROR;
                    job.code = ERR_SHORT_PAYLOAD;
                    n_halted = 1'b1;
                end else if (r_hcnt != 2'd0) begin
                    job_vld  = 1'b1;
                    job.kind = KIND_ERROR;
                    job.code = ERR_SHORT_HEADER;
                    n_halted = 1'b1;
                end else if (r_fill != '0) begin
                    job_vld    = 1'b1;
                    job.kind   = KIND_PACKET;
                    job.length = 11'(r_fill);
                    n_fill     = '0;
                end
            end else if (r_in_pay) begin
                job_vld    = 1'b1;
                job.data   = i_in_byte;
                job.offset = 10'(r_fill);
                n_fill     = r_fill + FW'(1);
                n_left     = r_left - SIZE_W'(1);
                if (r_left == SIZE_W'(1)) begin
                    n_in_pay = 1'b0;
                end
            end else if (r_hcnt == 2'(HEADER_BYTES - 1)) begin
                n_hcnt = 2'd0;
                if (r_hold0 != SYNC_BYTE) begin
                    job_vld  = 1'b1;
                    job.kind = KIND_ERROR;
                    job.code = ERR_BAD_SYNC;
                    n_halted = 1'b1;
                end else if (CW'(r_size) > CW'(r_cap) - CW'(HEADER_BYTES)) begin
                    job_vld  = 1'b1;
                    job.kind = KIND_ERROR;
                    job.code = ERR_TOO_LARGE;
                    n_halted = 1'b1;
                end else begin
                    job_vld   = 1'b1;
                    job.hdr   = 1'b1;
                    // previous packet closes if this frame would overflow it
                    job.flush = (CW'(r_fill) + CW'(HEADER_BYTES) + CW'(r_size)) > CW'(r_cap);
                    if (job.flush) begin
                        base = '0;
                    end
                    job.length    = 11'(r_fill);
                    job.offset    = 10'(base);
                    job.hbytes[0] = r_hold0;
                    job.hbytes[1] = r_hold1;
                    job.hbytes[2] = r_hold2;
                    job.hbytes[3] = i_in_byte;
                    n_fill        = base + FW'(HEADER_BYTES);
                    n_left        = r_size;
                    n_in_pay      = (r_size != '0);
                end
            end else begin
                n_hcnt = r_hcnt + 2'd1;
            end
        end
    end

    assign o_job_push = job_vld;
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt   <= 2'd0;
            r_in_pay <= 1'b0;
            r_halted <= 1'b0;
            r_left   <= '0;
            r_fill   <= '0;
            r_cap    <= FW'(CAP_RST);
        end else begin
            r_hcnt   <= n_hcnt;
            r_in_pay <= n_in_pay;
            r_halted <= n_halted;
            r_left   <= n_left;
            r_fill   <= n_fill;
            if (i_cfg_valid) begin
                if (32'(i_cfg_data) < 32'(CAPACITY_MIN)) begin
                    r_cap <= FW'(CAPACITY_MIN);
                end else if (32'(i_cfg_data) > 32'(MAX_CAPACITY)) begin
                    r_cap <= FW'(MAX_CAPACITY);
                end else begin
                    r_cap <= FW'(i_cfg_data);
                end
            end
        end
    end

    // header bytes; the size is worked out as the bitpool byte arrives
    always_ff @(posedge i_clk) begin
        if (accept && !r_halted && !i_command && !r_in_pay) begin
            case (r_hcnt)
                2'd0: r_hold0 <= i_in_byte;
                2'd1: r_hold1 <= i_in_byte;
                2'd2: begin
                    r_hold2 <= i_in_byte;
                    r_size  <= f_payload_size(r_hold1, i_in_byte);
                end
                default: ;
            endcase
        end
    end

endmodule

/* hdl/sbcfp_job_queue.sv */
// ----------------------------------------------------------------------------
// sbcfp_job_queue
// Short register queue of jobs between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module sbcfp_job_queue #(
    parameter int DEPTH = sbcfp_pkg::JOB_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbcfp_pkg::t_job   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output sbcfp_pkg::t_job   o_data,
    output logic              o_empty
);
    import sbcfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job              r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [AW:0]       r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/sbcfp_back.sv */
// ----------------------------------------------------------------------------
// sbcfp_back
// Result sequencer: expands jobs into results in the output register, one
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module sbcfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbcfp_pkg::t_job     i_job,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_valid,
    output sbcfp_pkg::t_result  o_res
);
    import sbcfp_pkg::*;

    logic [2:0]  r_step, n_step;
    logic [2:0]  step;
    logic [1:0]  idx;
    logic        r_valid, n_valid;
    t_result     r_res, res;
    logic        take, emit, done;

    always_comb begin
        take = !r_valid || i_pop;
        emit = !i_job_empty && take;
        step = (i_job.hdr && !i_job.flush && r_step == 3'd0) ? 3'd1 : r_step;
        idx  = 2'(step - 3'd1);
        res  = '0;
        res.kind = KIND_BYTE;
        res.code = ERR_NONE;
        done = 1'b1;
        if (!i_job.hdr) begin
            res.kind   = i_job.kind;
            res.data   = i_job.data;
            res.offset = i_job.offset;
            res.length = i_job.length;
            res.code   = i_job.code;
            res.last   = 1'b1;
        end else if (step == 3'd0) begin
            // packet closes ahead of this frame's header
            res.kind   = KIND_PACKET;
            res.length = i_job.length;
            done       = 1'b0;
        end else begin
            res.data   = i_job.hbytes[idx];
            res.offset = i_job.offset + 10'(idx);
            done       = (step == 3'(HEADER_BYTES));
            res.last   = done;
        end
        n_step = r_step;
        if (emit) begin
            n_step = done ? 3'd0 : step + 3'd1;
        end
        if (emit) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    assign o_job_pop = emit && done;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= res;
        end
    end

endmodule

/* hdl/sbc_frame_packetizer_top.sv */
// ----------------------------------------------------------------------------
// sbc_frame_packetizer_top
// SBC frame packetizer: parses an SBC byte stream and packs frames into
// packets, giving each frame byte its packet offset.
// ----------------------------------------------------------------------------
// Input side is a queue write: drive i_command/i_in_byte with push; the
// transfer happens when push is high and full is low. i_command = 1 ends
// the stream. Results come out as a queue read: while empty is low the
// oldest result is on the o_ ports, and pop high transfers it.
// Configuration: i_cfg_valid/i_cfg_data write packet_capacity; o_cfg_ready is
// always high. Write only while the block is idle.
// Throughput: one input per cycle while full is low. Payload bytes and end
// commands give at most one result each; the last byte of a header that passes
// its checks gives four results, or five when the current packet closes first.
// The result sequencer drains one result per cycle while pop is high, behind
// a four-entry job queue. With pop held high and three or more payload bytes
// behind a header, the burst fills the queue and full stalls the input for
// each frame, and for longer when a packet closes. A transfer writes its job
// into the job queue, and the result sequencer moves the result from there
// into the output register. When pop is held low the output register holds,
// the job queue fills and full rises; nothing is lost. After an error the
// block gives no more results until reset. Synchronous reset restores
// capacity 330 and an empty packet; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sbc_frame_packetizer_top #(
    parameter int MAX_CAPACITY = sbcfp_pkg::MAX_CAPACITY_DEF,
    parameter int JOB_DEPTH    = sbcfp_pkg::JOB_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [9:0]  o_byte_offset,
    output logic [10:0] o_packet_length,
    output logic [2:0]  o_error_code,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import sbcfp_pkg::*;

    t_job     fe_job, q_job;
    logic     fe_push, q_full, q_empty, q_pop;
    logic     res_valid;
    t_result  res;

    sbcfp_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_command   (i_command),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (fe_push),
        .o_job       (fe_job)
    );

    sbcfp_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (fe_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    sbcfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_valid     (res_valid),
        .o_res       (res)
    );

    assign full            = q_full;
    assign empty           = !res_valid;
    assign o_kind          = res.kind;
    assign o_out_byte      = res.data;
    assign o_byte_offset   = res.offset;
    assign o_packet_length = res.length;
    assign o_error_code    = res.code;
    assign o_last          = res.last;
    assign o_cfg_ready     = 1'b1;

endmodule

/* hdl/sbcfp_checker.sv */
// ----------------------------------------------------------------------------
// sbcfp_checker
// Port-level checks on the result channel of the packetizer.
// ----------------------------------------------------------------------------
module sbcfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [9:0]  o_byte_offset,
    input logic [10:0] o_packet_length,
    input logic [2:0]  o_error_code,
    input logic        o_last
);
    import sbcfp_pkg::*;

    // an error is the final result the block ever gives before reset
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_kind == KIND_ERROR) |=> empty)
        else $error("result after error");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ERROR) |-> (o_last && o_error_code != ERR_NONE))
        else $error("error result malformed");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_BYTE) |-> (o_packet_length == 11'd0 &&
                                            o_error_code == ERR_NONE))
        else $error("frame byte carries length or code");

    a_packet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_PACKET) |-> (o_packet_length != 11'd0 &&
                                              o_byte_offset == 10'd0))
        else $error("packet-ready result malformed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind == KIND_BYTE || o_kind == KIND_PACKET || o_kind == KIND_ERROR))
        else $error("undefined result kind");

endmodule

bind sbc_frame_packetizer_top sbcfp_checker u_checker (.*);

/* bench/sbc_frame_packetizer_top_tb.sv */
// ----------------------------------------------------------------------------
// sbc_frame_packetizer_top_tb
// Self-checking bench for the SBC frame packetizer. A directed table covers
// the reset capacity, field extremes and clean-end flushes. Random phases then
// send well-formed frames under several packet capacities, including the
// clamped extremes, one frame that fills a whole packet and a capacity cut
// below the current fill. One randomly chosen error ends the stream, followed
// by input that must be ignored. Every result is checked against an internal
// model of the deframer, and both handshakes idle at random.
// ----------------------------------------------------------------------------
module sbc_frame_packetizer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sbcfp_pkg::*;

    localparam logic       CMD_BYTE    = 1'b0;
    localparam logic       CMD_END     = 1'b1;
    localparam logic [1:0] MODE_MONO   = 2'd0;
    localparam logic [1:0] MODE_DUAL   = 2'd1;
    localparam logic [1:0] MODE_STEREO = 2'd2;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       typed;
        t_result    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        i_command = 1'b0;
    logic [7:0]  i_in_byte = 8'd0;
    logic        pop = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [10:0] i_cfg_data = 11'd0;
    logic        full;
    logic        empty;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [9:0]  o_byte_offset;
    logic [10:0] o_packet_length;
    logic [2:0]  o_error_code;
    logic        o_last;
    logic        o_cfg_ready;

    // deframer model state
    logic [7:0]  hdr_hold [0:HEADER_BYTES-1];
    int          hdr_count = 0;
    int          payload_due = 0;
    int          pkt_fill = 0;
    bit          in_payload = 1'b0;
    bit          halted = 1'b0;
    logic [10:0] capacity = 11'(CAPACITY_RESET);

    t_result     pending_results [$];
    int          errors = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    sbc_frame_packetizer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_in_byte      (i_in_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_byte_offset  (o_byte_offset),
        .o_packet_length(o_packet_length),
        .o_error_code   (o_error_code),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sbc_frame_packetizer_top_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int got, input int want_v);
        if (got != want_v)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want_v));
    endtask

    function automatic t_result mk_result(input t_kind k, input logic [7:0] d, input int off,
                                          input int len, input t_err c);
        t_result r;
        r.kind   = k;
        r.data   = d;
        r.offset = 10'(off);
        r.length = 11'(len);
        r.code   = c;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_row plain(input logic cmd, input logic [7:0] d);
        t_row r;
        r.cmd   = cmd;
        r.data  = d;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input logic cmd, input logic [7:0] d, input t_result w);
        t_row r;
        r.cmd       = cmd;
        r.data      = d;
        r.typed     = 1'b1;
        r.want      = w;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic int eff_capacity();
        if (capacity < 11'(CAPACITY_MIN))
            return CAPACITY_MIN;
        if (capacity > 11'(MAX_CAPACITY_DEF))
            return MAX_CAPACITY_DEF;
        return int'(capacity);
    endfunction

    function automatic int sbc_payload_len(input logic [7:0] mode_byte, input logic [7:0] pool);
        int sb;
        int blk;
        int bits;
        sb  = mode_byte[0] ? 8 : 4;
        blk = (int'(mode_byte[5:4]) + 1) * 4;
        case (mode_byte[3:2])
            MODE_MONO: begin
                sb   = sb / 2;
                bits = blk * int'(pool);
            end
            MODE_DUAL:   bits = 2 * blk * int'(pool);
            MODE_STEREO: bits = blk * int'(pool);
            default:     bits = blk * int'(pool) + sb;
        endcase
        return sb + (bits + 7) / 8;
    endfunction

    // Advances the model by one accepted input and queues what it produces.
    function automatic void packetize(input t_row r);
        t_result burst [$];
        int      cap;
        int      size;
        if (!halted) begin
            if (r.cmd == CMD_END) begin
                if (in_payload) begin
                    burst.push_back(mk_result(KIND_ERROR, 8'd0, 0, 0, ERR_SHORT_PAYLOAD));
                    halted = 1'b1;
                end else if (hdr_count != 0) begin
                    burst.push_back(mk_result(KIND_ERROR, 8'd0, 0, 0, ERR_SHORT_HEADER));
                    halted = 1'b1;
                end else if (pkt_fill != 0) begin
                    burst.push_back(mk_result(KIND_PACKET, 8'd0, 0, pkt_fill, ERR_NONE));
                    pkt_fill = 0;
                end
            end else if (in_payload) begin
                burst.push_back(mk_result(KIND_BYTE, r.data, pkt_fill, 0, ERR_NONE));
                pkt_fill++;
                payload_due--;
                if (payload_due == 0)
                    in_payload = 1'b0;
            end else begin
                hdr_hold[hdr_count] = r.data;
                hdr_count++;
                if (hdr_count == HEADER_BYTES) begin
                    hdr_count = 0;
                    cap = eff_capacity();
                    size = sbc_payload_len(hdr_hold[1], hdr_hold[2]);
                    if (hdr_hold[0] != SYNC_BYTE) begin
                        burst.push_back(mk_result(KIND_ERROR, 8'd0, 0, 0, ERR_BAD_SYNC));
                        halted = 1'b1;
                    end else if (size > cap - HEADER_BYTES) begin
                        burst.push_back(mk_result(KIND_ERROR, 8'd0, 0, 0, ERR_TOO_LARGE));
                        halted = 1'b1;
                    end else begin
                        // frame does not fit: close the current packet first
                        if (pkt_fill + HEADER_BYTES + size > cap) begin
                            burst.push_back(mk_result(KIND_PACKET, 8'd0, 0, pkt_fill, ERR_NONE));
                            pkt_fill = 0;
                        end
                        for (int i = 0; i < HEADER_BYTES; i++) begin
                            burst.push_back(mk_result(KIND_BYTE, hdr_hold[i], pkt_fill, 0,
                                                      ERR_NONE));
                            pkt_fill++;
                        end
                        payload_due = size;
                        in_payload = (size != 0);
                    end
                end
            end
        end
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        if (r.typed) begin
            burst.delete();
            burst.push_back(r.want);
        end
        foreach (burst[i])
            pending_results.push_back(burst[i]);
    endfunction

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_item(input t_row r);
        while (!no_idle && $urandom_range(0, 99) < 30) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_command <= r.cmd;
        i_in_byte <= r.data;
        do @(posedge i_clk); while (full);
        packetize(r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        // inputs that make no result may still be in flight
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [10:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        capacity = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] mode_byte, input logic [7:0] pool,
                              output int count);
        int size;
        size = sbc_payload_len(mode_byte, pool);
        send_item(plain(CMD_BYTE, SYNC_BYTE));
        send_item(plain(CMD_BYTE, mode_byte));
        send_item(plain(CMD_BYTE, pool));
        send_item(plain(CMD_BYTE, 8'($urandom_range(0, 255))));
        for (int i = 0; i < size; i++)
            send_item(plain(CMD_BYTE, 8'($urandom_range(0, 255))));
        count = HEADER_BYTES + size;
    endtask

    // Well-formed frames sized to fit the capacity, with stray clean ends.
    task automatic random_traffic(input int budget);
        int         sent;
        int         limit;
        int         count;
        logic [7:0] mode_byte;
        logic [7:0] pool;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(plain(CMD_END, 8'($urandom_range(0, 255))));
                sent++;
            end
            limit = eff_capacity() - HEADER_BYTES;
            if ($urandom_range(0, 99) < 10) begin
                if (limit > 60)
                    limit = 60;
            end else if (limit > 24) begin
                limit = $urandom_range(2, 24);
            end
            mode_byte = 8'($urandom_range(0, 255));
            pool      = 8'($urandom_range(0, 255));
            while (sbc_payload_len(mode_byte, pool) > limit && pool != 8'd0)
                pool = pool >> 1;
            if (sbc_payload_len(mode_byte, pool) > limit)
                mode_byte = mode_byte & 8'hF2;  // mono, four subbands
            send_frame(mode_byte, pool, count);
            sent += count;
        end
    endtask

    always @(negedge i_clk)
        pop <= no_idle || ($urandom_range(0, 99) >= 30);

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("kind", o_kind, want.kind);
                check_field("out_byte", o_out_byte, want.data);
                check_field("byte_offset", o_byte_offset, want.offset);
                check_field("packet_length", o_packet_length, want.length);
                check_field("error_code", o_error_code, want.code);
                check_field("last", o_last, want.last);
            end
        end
    end

    initial begin : stimulus
        t_row directed_rows [$];
        t_row tail_rows [$];
        int   count;
        foreach (hdr_hold[i])
            hdr_hold[i] = 8'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset capacity; mono 4-subband frame, then a joint 8-subband frame in
        // the same packet, flushed by a clean end
        directed_rows = '{
            plain(CMD_END, 8'h00),
            plain(CMD_BYTE, SYNC_BYTE), plain(CMD_BYTE, 8'h00), plain(CMD_BYTE, 8'h00),
            plain(CMD_BYTE, 8'h00),
            typed_row(CMD_BYTE, 8'h00, mk_result(KIND_BYTE, 8'h00, 4, 0, ERR_NONE)),
            typed_row(CMD_BYTE, 8'hFF, mk_result(KIND_BYTE, 8'hFF, 5, 0, ERR_NONE)),
            plain(CMD_BYTE, SYNC_BYTE), plain(CMD_BYTE, 8'hFF), plain(CMD_BYTE, 8'h00),
            plain(CMD_BYTE, 8'hFF),
            plain(CMD_BYTE, 8'h55), plain(CMD_BYTE, 8'hAA), plain(CMD_BYTE, 8'h01),
            plain(CMD_BYTE, 8'h02), plain(CMD_BYTE, 8'h04), plain(CMD_BYTE, 8'h08),
            plain(CMD_BYTE, 8'h10), plain(CMD_BYTE, 8'h20), plain(CMD_BYTE, 8'h80),
            typed_row(CMD_END, 8'hFF, mk_result(KIND_PACKET, 8'h00, 0, 19, ERR_NONE))
        };
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // above range clamps to the maximum
        write_capacity(11'd2047);
        random_traffic(8);
        // fill is normally above the new capacity, so the next frame closes it
        write_capacity(11'd0);
        random_traffic(4);
        write_capacity(11'(CAPACITY_MIN));
        random_traffic(4);
        no_idle = 1'b1;
        write_capacity(11'(MAX_CAPACITY_DEF));
        random_traffic(16);
        wait_drained();
        no_idle = 1'b0;
        // joint 8-subband frame with bitpool 0 fills a 13-byte packet exactly
        write_capacity(11'd13);
        send_frame(8'hFF, 8'd0, count);
        random_traffic(4);
        write_capacity(11'($urandom_range(CAPACITY_MIN, MAX_CAPACITY_DEF)));
        random_traffic(4);
        write_capacity(11'(CAPACITY_RESET));
        random_traffic(4);

        // one error halts the block for the rest of the run
        case ($urandom_range(0, 3))
            0: tail_rows = '{
                plain(CMD_BYTE, 8'h9D), plain(CMD_BYTE, 8'h00), plain(CMD_BYTE, 8'h00),
                typed_row(CMD_BYTE, 8'h00, mk_result(KIND_ERROR, 8'h00, 0, 0, ERR_BAD_SYNC))
            };
            1: tail_rows = '{
                plain(CMD_BYTE, SYNC_BYTE), plain(CMD_BYTE, 8'h35), plain(CMD_BYTE, 8'hFF),
                typed_row(CMD_BYTE, 8'h00, mk_result(KIND_ERROR, 8'h00, 0, 0, ERR_TOO_LARGE))
            };
            2: tail_rows = '{
                plain(CMD_BYTE, SYNC_BYTE), plain(CMD_BYTE, 8'h00),
                typed_row(CMD_END, 8'h00,
                          mk_result(KIND_ERROR, 8'h00, 0, 0, ERR_SHORT_HEADER))
            };
            default: tail_rows = '{
                plain(CMD_BYTE, SYNC_BYTE), plain(CMD_BYTE, 8'h00), plain(CMD_BYTE, 8'h00),
                plain(CMD_BYTE, 8'h00), plain(CMD_BYTE, 8'h5A),
                typed_row(CMD_END, 8'h00,
                          mk_result(KIND_ERROR, 8'h00, 0, 0, ERR_SHORT_PAYLOAD))
            };
        endcase
        foreach (tail_rows[i])
            send_item(tail_rows[i]);
        repeat (4)
            send_item(plain(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("sbc_frame_packetizer_top_tb: PASS");
        else
            $display("sbc_frame_packetizer_top_tb: FAIL");
        $finish;
    end

endmodule
